// ===== hw/rtl/s384_pkg.sv =====
// Shared types, constants and SHA-384 round functions for the hash engine.
// Used by s384_ctrl, s384_dp and sha384_hash_engine; depends on nothing.
package s384_pkg;

	typedef struct packed {
		logic [63:0] msg_word;
		logic [3:0]  byte_count;
		logic        last;
	} msg_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        digest_invalid;
	} dig_item_t;

	// Source of the 16 schedule words loaded at the start of a compression.
	typedef enum logic [1:0] {
		SRC_BUF  = 2'd0,
		SRC_PAD1 = 2'd1,
		SRC_PAD2 = 2'd2
	} blk_src_t;

	typedef struct packed {
		logic       capture;
		logic       absorb;
		logic       wrap;
		logic       load;
		blk_src_t   src;
		logic       clear;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic invalid;
		logic rem_ge112;
		logic comp_done;
	} dp_sts_t;

	localparam int unsigned NumRounds = 80;
	localparam int unsigned DigWords  = 6;
	localparam logic [6:0]  PadLimit  = 7'd112;

	localparam logic [7:0][63:0] InitHash = {
		64'h47B5481DBEFA4FA4, 64'hDB0C2E0D64F98FA7,
		64'h8EB44A8768581511, 64'h67332667FFC00B31,
		64'h152FECD8F70E5939, 64'h9159015A3070DD17,
		64'h629A292A367CD507, 64'hCBBB9D5DC1059ED8
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [63:0] ssig0(input logic [63:0] x);
		ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] ssig1(input logic [63:0] x);
		ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k;
		case (t)
			7'd0:  k = 64'h428A2F98D728AE22;  7'd1:  k = 64'h7137449123EF65CD;
			7'd2:  k = 64'hB5C0FBCFEC4D3B2F;  7'd3:  k = 64'hE9B5DBA58189DBBC;
			7'd4:  k = 64'h3956C25BF348B538;  7'd5:  k = 64'h59F111F1B605D019;
			7'd6:  k = 64'h923F82A4AF194F9B;  7'd7:  k = 64'hAB1C5ED5DA6D8118;
			7'd8:  k = 64'hD807AA98A3030242;  7'd9:  k = 64'h12835B0145706FBE;
			7'd10: k = 64'h243185BE4EE4B28C;  7'd11: k = 64'h550C7DC3D5FFB4E2;
			7'd12: k = 64'h72BE5D74F27B896F;  7'd13: k = 64'h80DEB1FE3B1696B1;
			7'd14: k = 64'h9BDC06A725C71235;  7'd15: k = 64'hC19BF174CF692694;
			7'd16: k = 64'hE49B69C19EF14AD2;  7'd17: k = 64'hEFBE4786384F25E3;
			7'd18: k = 64'h0FC19DC68B8CD5B5;  7'd19: k = 64'h240CA1CC77AC9C65;
			7'd20: k = 64'h2DE92C6F592B0275;  7'd21: k = 64'h4A7484AA6EA6E483;
			7'd22: k = 64'h5CB0A9DCBD41FBD4;  7'd23: k = 64'h76F988DA831153B5;
			7'd24: k = 64'h983E5152EE66DFAB;  7'd25: k = 64'hA831C66D2DB43210;
			7'd26: k = 64'hB00327C898FB213F;  7'd27: k = 64'hBF597FC7BEEF0EE4;
			7'd28: k = 64'hC6E00BF33DA88FC2;  7'd29: k = 64'hD5A79147930AA725;
			7'd30: k = 64'h06CA6351E003826F;  7'd31: k = 64'h142929670A0E6E70;
			7'd32: k = 64'h27B70A8546D22FFC;  7'd33: k = 64'h2E1B21385C26C926;
			7'd34: k = 64'h4D2C6DFC5AC42AED;  7'd35: k = 64'h53380D139D95B3DF;
			7'd36: k = 64'h650A73548BAF63DE;  7'd37: k = 64'h766A0ABB3C77B2A8;
			7'd38: k = 64'h81C2C92E47EDAEE6;  7'd39: k = 64'h92722C851482353B;
			7'd40: k = 64'hA2BFE8A14CF10364;  7'd41: k = 64'hA81A664BBC423001;
			7'd42: k = 64'hC24B8B70D0F89791;  7'd43: k = 64'hC76C51A30654BE30;
			7'd44: k = 64'hD192E819D6EF5218;  7'd45: k = 64'hD69906245565A910;
			7'd46: k = 64'hF40E35855771202A;  7'd47: k = 64'h106AA07032BBD1B8;
			7'd48: k = 64'h19A4C116B8D2D0C8;  7'd49: k = 64'h1E376C085141AB53;
			7'd50: k = 64'h2748774CDF8EEB99;  7'd51: k = 64'h34B0BCB5E19B48A8;
			7'd52: k = 64'h391C0CB3C5C95A63;  7'd53: k = 64'h4ED8AA4AE3418ACB;
			7'd54: k = 64'h5B9CCA4F7763E373;  7'd55: k = 64'h682E6FF3D6B2B8A3;
			7'd56: k = 64'h748F82EE5DEFB2FC;  7'd57: k = 64'h78A5636F43172F60;
			7'd58: k = 64'h84C87814A1F0AB72;  7'd59: k = 64'h8CC702081A6439EC;
			7'd60: k = 64'h90BEFFFA23631E28;  7'd61: k = 64'hA4506CEBDE82BDE9;
			7'd62: k = 64'hBEF9A3F7B2C67915;  7'd63: k = 64'hC67178F2E372532B;
			7'd64: k = 64'hCA273ECEEA26619C;  7'd65: k = 64'hD186B8C721C0C207;
			7'd66: k = 64'hEADA7DD6CDE0EB1E;  7'd67: k = 64'hF57D4F7FEE6ED178;
			7'd68: k = 64'h06F067AA72176FBA;  7'd69: k = 64'h0A637DC5A2C898A6;
			7'd70: k = 64'h113F9804BEF90DAE;  7'd71: k = 64'h1B710B35131C471B;
			7'd72: k = 64'h28DB77F523047D84;  7'd73: k = 64'h32CAAB7B40C72493;
			7'd74: k = 64'h3C9EBE0A15C9BEBC;  7'd75: k = 64'h431D67C49C100D4C;
			7'd76: k = 64'h4CC5D4BECB3E42B6;  7'd77: k = 64'h597F299CFC657E2A;
			7'd78: k = 64'h5FCB6FAB3AD6FAEC;  7'd79: k = 64'h6C44198C4A475817;
			default: k = 64'h0;
		endcase
		round_k = k;
	endfunction

endpackage

// ===== hw/rtl/s384_dp.sv =====
// Datapath of the SHA-384 engine: item register, block buffer, length
// counter, padding, round unit and chaining state. Depends on s384_pkg.
module s384_dp import s384_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  msg_item_t msg,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output dig_item_t dig
);

	msg_item_t   item_q;
	logic [63:0] hash_q [8];
	logic [63:0] buf_q [16];
	logic [6:0]  bytes_q;
	logic [63:0] len_q;
	logic        inv_q;
	logic [63:0] w_q [16];
	logic [63:0] v_q [8];
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic        fold_q;
	logic [63:0] lo_data_q;
	logic [7:0]  lo_be_q;

	logic [3:0]   n;
	logic [64:0]  len_sum;
	logic         ovf;
	logic         act;
	logic [7:0]   be8;
	logic [63:0]  dmask;
	logic [127:0] sh128;
	logic [15:0]  be16;
	logic [2:0]   off;
	logic [3:0]   wi;
	logic [3:0]   wi_n;
	logic [7:0]   pos_sum;
	logic         ge112;
	logic [63:0]  pad1 [16];
	logic [63:0]  pad2 [16];
	logic [63:0]  src_w [16];
	logic [63:0]  t1;
	logic [63:0]  t2;
	logic [63:0]  w_new;

	always_comb begin
		n = (item_q.byte_count > 4'd8) ? 4'd8 : item_q.byte_count;
		len_sum = {1'b0, len_q} + {61'b0, n};
		ovf = len_sum[64];
		act = !inv_q && (n != 4'd0);
		be8 = ~(8'hFF >> n);
		for (int k = 0; k < 8; k++) begin
			dmask[8*k +: 8] = {8{be8[k]}};
		end
		off = bytes_q[2:0];
		wi = bytes_q[6:3];
		wi_n = wi + 4'd1;
		sh128 = {item_q.msg_word & dmask, 64'b0} >> {off, 3'b0};
		be16 = {be8, 8'b0} >> off;
		pos_sum = {1'b0, bytes_q} + {4'b0, n};
		ge112 = bytes_q >= PadLimit;
	end

	// Final block: written bytes kept, the rest zero, then the pad byte and
	// the bit length when it fits.
	always_comb begin
		logic [7:0] start;
		logic [7:0] rem8;
		logic [63:0] wm;
		rem8 = {1'b0, bytes_q};
		for (int i = 0; i < 16; i++) begin
			start = 8'(i * 8);
			if (start + 8'd8 <= rem8) begin
				wm = '1;
			end else if (start >= rem8) begin
				wm = '0;
			end else begin
				wm = ~(64'hFFFF_FFFF_FFFF_FFFF >> {rem8[2:0], 3'b0});
			end
			pad1[i] = buf_q[i] & wm;
			if (4'(i) == wi) begin
				pad1[i] = pad1[i] | (64'h8000_0000_0000_0000 >> {off, 3'b0});
			end
			pad2[i] = '0;
		end
		pad2[14] = {61'b0, len_q[63:61]};
		pad2[15] = {len_q[60:0], 3'b0};
		if (!ge112) begin
			pad1[14] = pad2[14];
			pad1[15] = pad2[15];
		end
		for (int i = 0; i < 16; i++) begin
			case (cmd.src)
				SRC_PAD1: src_w[i] = pad1[i];
				SRC_PAD2: src_w[i] = pad2[i];
				default:  src_w[i] = buf_q[i];
			endcase
		end
	end

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(rnd_q) + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= msg;
		end
		if (cmd.absorb && act && !ovf) begin
			for (int k = 0; k < 8; k++) begin
				if (be16[8+k]) begin
					buf_q[wi][8*k +: 8] <= sh128[64 + 8*k +: 8];
				end
				if (be16[k] && (wi != 4'd15)) begin
					buf_q[wi_n][8*k +: 8] <= sh128[8*k +: 8];
				end
			end
			lo_data_q <= sh128[63:0];
			lo_be_q <= be16[7:0];
		end
		if (cmd.wrap) begin
			for (int k = 0; k < 8; k++) begin
				if (lo_be_q[k]) begin
					buf_q[0][8*k +: 8] <= lo_data_q[8*k +: 8];
				end
			end
		end
		if (cmd.load) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= src_w[i];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= InitHash[i];
			end
			bytes_q <= '0;
			len_q <= '0;
			inv_q <= 1'b0;
			rnd_q <= '0;
			busy_q <= 1'b0;
			fold_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= InitHash[i];
				end
				bytes_q <= '0;
				len_q <= '0;
				inv_q <= 1'b0;
			end else if (cmd.absorb && act) begin
				if (ovf) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= '0;
					end
					bytes_q <= '0;
					len_q <= '0;
					inv_q <= 1'b1;
				end else begin
					bytes_q <= pos_sum[6:0];
					len_q <= len_sum[63:0];
				end
			end else if (fold_q) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
			fold_q <= 1'b0;
			if (cmd.load) begin
				rnd_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(NumRounds - 1)) begin
					busy_q <= 1'b0;
					fold_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts.full = act && !ovf && pos_sum[7];
		sts.last = item_q.last;
		sts.invalid = inv_q;
		sts.rem_ge112 = ge112;
		sts.comp_done = fold_q;
		dig.digest_word = inv_q ? 64'b0 : hash_q[cmd.out_idx];
		dig.word_index = cmd.out_idx;
		dig.last_word = cmd.out_idx == 3'(DigWords - 1);
		dig.digest_invalid = inv_q;
	end

endmodule

// ===== hw/rtl/s384_ctrl.sv =====
// Sequencer of the SHA-384 engine: absorbs items, starts compressions,
// runs the padding blocks and hands out the digest. Depends on s384_pkg.
module s384_ctrl import s384_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	output logic    msg_stall,
	output logic    dig_valid,
	input  logic    dig_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ABS  = 9'b000000010,
		S_WRAP = 9'b000000100,
		S_WBLK = 9'b000001000,
		S_FIN  = 9'b000010000,
		S_WP1  = 9'b000100000,
		S_LP2  = 9'b001000000,
		S_WP2  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] idx_q;
	logic       dig_acc;

	assign msg_stall = state_q != S_IDLE;
	assign dig_valid = state_q == S_OUT;
	assign dig_acc = dig_valid && !dig_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = SRC_BUF;
		cmd.out_idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = msg_valid;
				if (msg_valid) begin
					state_d = S_ABS;
				end
			end
			S_ABS: begin
				cmd.absorb = 1'b1;
				if (sts.full) begin
					state_d = S_WRAP;
				end else if (sts.last) begin
					state_d = S_FIN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				cmd.load = 1'b1;
				state_d = S_WBLK;
			end
			S_WBLK: begin
				if (sts.comp_done) begin
					state_d = sts.last ? S_FIN : S_IDLE;
				end
			end
			S_FIN: begin
				if (sts.invalid) begin
					state_d = S_OUT;
				end else begin
					cmd.load = 1'b1;
					cmd.src = SRC_PAD1;
					state_d = S_WP1;
				end
			end
			S_WP1: begin
				if (sts.comp_done) begin
					state_d = sts.rem_ge112 ? S_LP2 : S_OUT;
				end
			end
			S_LP2: begin
				cmd.load = 1'b1;
				cmd.src = SRC_PAD2;
				state_d = S_WP2;
			end
			S_WP2: begin
				if (sts.comp_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (dig_acc && idx_q == 3'(DigWords - 1)) begin
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (dig_acc) begin
				idx_q <= (idx_q == 3'(DigWords - 1)) ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/sha384_hash_engine.sv =====
// Top level of the streaming SHA-384 engine.
// Instantiates s384_ctrl and s384_dp; depends on s384_pkg.
//
// The engine takes a message as big-endian 64-bit items on the msg channel,
// each with a byte count (counts above eight count as eight) and a last flag,
// and returns the 384-bit digest as six items on the dig channel, most
// significant word first. Bytes are appended at byte granularity, so short
// items may appear anywhere. One item is in work at a time: an item that
// does not complete a block passes through capture and absorb; an item
// that completes a 128-byte block also waits for the round unit, which
// runs one SHA-512 round per cycle for 80 rounds plus a load and a
// feed-forward add. A last item adds one or two padding blocks (none
// after an overflow) before the six digest items are offered. If the 64-bit
// byte count would wrap, the state is cleared and later bytes are ignored;
// the digest that follows the next last item is all zeros with
// digest_invalid set. After every digest the engine returns to its
// initial state.
module sha384_hash_engine import s384_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The sequencer decides which step runs in each cycle.
	s384_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds all message, length and chaining state.
	s384_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cmd    (cmd),
		.sts    (sts),
		.dig    (dig)
	);

endmodule

// ===== tb/tb_sha384_hash_engine.sv =====
// Self-checking testbench for the streaming SHA-384 engine sha384_hash_engine.
// Depends on s384_pkg for the item types and the initial hash values; holds its
// own SHA-384 predictor and compares every digest item against it.
module tb_sha384_hash_engine;
	import s384_pkg::*;

	localparam int unsigned CycleLimit = 600000;

	logic      clk;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_item_t msg;
	logic      dig_valid;
	logic      dig_stall;
	dig_item_t dig;

	sha384_hash_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Digest items that the predictor says the engine still owes us, oldest first.
	dig_item_t   pending_digest[$];
	int unsigned mismatches;
	int unsigned cycles;
	// When set, neither side inserts idle cycles, so back-to-back traffic is seen too.
	bit          no_idle;

	// Predictor state: chaining words, partial block, fill level and byte length.
	logic [63:0] chain[8];
	logic [63:0] partial_blk[16];
	int unsigned fill_bytes;
	logic [63:0] msg_bytes;
	bit          overflowed;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One SHA-512 compression of a 16-word block into the chaining words.
	function automatic void compress_block(input logic [63:0] blk[16]);
		logic [63:0] w[80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		logic [63:0] k[80];
		k = '{
			64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
			64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
			64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
			64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
			64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
			64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
			64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
			64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
			64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
			64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
			64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
			64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
			64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
			64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
			64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
			64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
			64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
			64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
			64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
			64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
		};
		for (int t = 0; t < 16; t++) w[t] = blk[t];
		for (int t = 16; t < 80; t++) begin
			s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
			s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int t = 0; t < 80; t++) begin
			t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
				+ k[t] + w[t];
			t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
		for (int i = 0; i < 16; i++) partial_blk[i] = '0;
		fill_bytes = 0;
		msg_bytes  = '0;
		overflowed = 0;
	endfunction

	// Absorbs one accepted item and queues the six digest items after a last one.
	function automatic void hash_item(input msg_item_t it);
		int unsigned n;
		logic [63:0] blk[16];
		dig_item_t   d;
		n = (it.byte_count > 8) ? 8 : it.byte_count;
		if (!overflowed && n != 0) begin
			if (msg_bytes > 64'hFFFF_FFFF_FFFF_FFFF - 64'(n)) begin
				for (int i = 0; i < 8; i++) chain[i] = '0;
				for (int i = 0; i < 16; i++) partial_blk[i] = '0;
				fill_bytes = 0;
				msg_bytes  = '0;
				overflowed = 1;
			end else begin
				for (int i = 0; i < n; i++) begin
					partial_blk[fill_bytes >> 3][63 - 8 * (fill_bytes % 8) -: 8] =
						it.msg_word[63 - 8 * i -: 8];
					fill_bytes++;
					if (fill_bytes == 128) begin
						compress_block(partial_blk);
						fill_bytes = 0;
					end
				end
				msg_bytes += 64'(n);
			end
		end
		if (!it.last) return;
		if (!overflowed) begin
			// Only the bytes written for this block count; the rest are zero fill.
			for (int i = 0; i < 16; i++) blk[i] = '0;
			for (int p = 0; p < fill_bytes; p++)
				blk[p >> 3][63 - 8 * (p % 8) -: 8] = partial_blk[p >> 3][63 - 8 * (p % 8) -: 8];
			blk[fill_bytes >> 3][63 - 8 * (fill_bytes % 8) -: 8] = 8'h80;
			if (fill_bytes >= 112) begin
				compress_block(blk);
				for (int i = 0; i < 16; i++) blk[i] = '0;
			end
			blk[14] = msg_bytes >> 61;
			blk[15] = msg_bytes << 3;
			compress_block(blk);
		end
		for (int j = 0; j < 6; j++) begin
			d.digest_word    = overflowed ? '0 : chain[j];
			d.word_index     = 3'(j);
			d.last_word      = (j == 5);
			d.digest_invalid = overflowed;
			pending_digest.push_back(d);
		end
		restart_hash();
	endfunction

	// Offers one item after a random gap and waits until the engine takes it.
	task automatic send_item(input msg_item_t it);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg       <= it;
		do @(posedge clk); while (msg_stall);
		hash_item(it);
	endtask

	task automatic send_word(input logic [63:0] w, input int unsigned cnt, input bit lst);
		msg_item_t it;
		it.msg_word   = w;
		it.byte_count = 4'(cnt);
		it.last       = lst;
		send_item(it);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Empty message, the classic "abc" vector and all-zero / all-one words.
	task automatic test_known_vectors();
		send_word(64'h0, 0, 1);
		send_word(64'h6162_6300_0000_0000, 3, 1);
		send_word(64'h0, 8, 1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 8, 1);
	endtask

	// Counts above eight must behave exactly as eight, on body and last items.
	task automatic test_count_above_eight();
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 15, 0);
		send_word(64'hA5A5_5A5A_0F0F_F0F0, 9, 1);
	endtask

	// Short body items and zero-byte body items are appended at byte granularity.
	task automatic test_short_body_items();
		send_word(64'h0123_4567_89AB_CDEF, 3, 0);
		send_word(64'hFEDC_BA98_7654_3210, 0, 0);
		send_word(64'h1122_3344_5566_7788, 8, 0);
		send_word(64'h99AA_BBCC_DDEE_FF00, 5, 0);
		send_word(64'hDEAD_BEEF_CAFE_F00D, 0, 1);
	endtask

	// Messages around the one-block / two-block padding boundary and whole blocks.
	task automatic test_block_boundaries();
		int unsigned lens[6] = '{111, 112, 119, 127, 128, 240};
		foreach (lens[m]) begin
			for (int b = 0; b < lens[m] / 8; b++) send_word(rand_word(), 8, 0);
			send_word(rand_word(), lens[m] % 8, 1);
		end
	endtask

	// The sender holds off until every owed digest item has come back.
	task automatic test_drain_pause();
		send_word(rand_word(), 8, 0);
		send_word(rand_word(), 6, 1);
		msg_valid <= 1'b0;
		while (pending_digest.size() != 0) @(posedge clk);
		send_word(rand_word(), 2, 1);
	endtask

	// Random messages: mostly well-formed (full body items, a last item of random count),
	// some with stray short or oversized body items, some sized near padding limits.
	task automatic test_random_messages();
		int unsigned sent, nitems, style;
		sent = 0;
		while (sent < 230) begin
			no_idle = ($urandom_range(0, 5) == 0);
			style   = $urandom_range(0, 9);
			nitems  = (style < 2) ? $urandom_range(13, 17) : $urandom_range(1, 8);
			for (int i = 0; i + 1 < nitems; i++)
				send_word(rand_word(), (style == 9) ? $urandom_range(0, 15) : 8, 0);
			send_word(rand_word(), $urandom_range(0, 15), 1);
			sent += nitems;
		end
		no_idle = 0;
	endtask

	// Receiver: a random stall before each digest item, none at all while no_idle is set.
	initial begin
		int unsigned hold;
		dig_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 9);
			if (hold != 0) begin
				dig_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			dig_stall <= 1'b0;
			do @(posedge clk); while (!dig_valid);
		end
	end

	// Compares each accepted digest item against the oldest prediction.
	always @(posedge clk) begin
		dig_item_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			if (pending_digest.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected digest item: %h idx %0d", dig.digest_word, dig.word_index);
			end else begin
				want = pending_digest.pop_front();
				if (dig !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Digest mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
							want.digest_word, want.word_index, want.last_word,
							want.digest_invalid, dig.digest_word, dig.word_index,
							dig.last_word, dig.digest_invalid);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles     = 0;
		no_idle    = 0;
		arst_n     = 1'b0;
		msg_valid  = 1'b0;
		msg        = '0;
		restart_hash();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_known_vectors();
		test_count_above_eight();
		test_short_body_items();
		test_block_boundaries();
		test_drain_pause();
		test_random_messages();

		msg_valid <= 1'b0;
		while (pending_digest.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
